// ===== hdl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants and codes for the random permutation shuffle block.
// ----------------------------------------------------------------------------
package rps_pkg;

   // Default permutation capacity (table depth)
   localparam int MAX_LENGTH_DEF = 256;

   // Fixed field widths
   localparam int FRAC_W = 16;   // random fraction, unsigned Q0.16
   localparam int LEN_W  = 9;    // perm_length register
   localparam int DATA_W = 8;    // slot and element result fields

   localparam logic [LEN_W-1:0] PERM_LENGTH_RST = 9'd256;

   // action codes (req_tuser)
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_DRAW  = 1'b1;

   // status codes (rsp_tuser)
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_EXHAUSTED = 1'b1;

endpackage

// ===== hdl/rps_table.sv =====
// ----------------------------------------------------------------------------
// rps_table
// Permutation table: memory with two registered read ports, one write port
// and per-entry valid bits. An entry not written since the last clear reads
// back as its own index.
// ----------------------------------------------------------------------------
module rps_table #(
   parameter int MAX_LENGTH = rps_pkg::MAX_LENGTH_DEF,
   parameter int IDX_W      = $clog2(MAX_LENGTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear_all,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_a_addr,
   input  logic [IDX_W-1:0] rd_b_addr,
   output logic [IDX_W-1:0] rd_a_data,
   output logic [IDX_W-1:0] rd_b_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] wr_data
);

   logic [IDX_W-1:0]      mem [MAX_LENGTH];
   logic [MAX_LENGTH-1:0] valid_ff;
   logic [IDX_W-1:0]      mem_a_ff, mem_b_ff;
   logic [IDX_W-1:0]      addr_a_ff, addr_b_ff;
   logic                  vld_a_ff, vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_a_ff  <= mem[rd_a_addr];
         mem_b_ff  <= mem[rd_b_addr];
         addr_a_ff <= rd_a_addr;
         addr_b_ff <= rd_b_addr;
      end
   end

   // clear wins over a write in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (clear_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_a_ff <= valid_ff[rd_a_addr];
            vld_b_ff <= valid_ff[rd_b_addr];
         end
      end
   end

   assign rd_a_data = vld_a_ff ? mem_a_ff : addr_a_ff;
   assign rd_b_data = vld_b_ff ? mem_b_ff : addr_b_ff;

endmodule

// ===== hdl/random_permutation_shuffle.sv =====
// ----------------------------------------------------------------------------
// random_permutation_shuffle
// Fisher-Yates shuffle: each draw fixes the top unfixed slot of a random
// permutation of 0..length-1 and returns that slot with its value.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | tuser = action, tdata = random_fraction
//  rsp_    | out       | tdata = {element, slot}, tlast = last, tuser = status
//  csr_    | in        | csr_data = perm_length
//
//  A draw reads the picked and top entries from the table in S_READ
//  (registered read), then writes the swap back and loads the result
//  register in S_WRITE. The next transaction is taken in that write cycle.
//  A start clears the valid bits at once and gives no result.
//  A held result register stalls the write cycle and with it the input.
//  Reset leaves a table of MAX_LENGTH entries, all reading as identity.
// ----------------------------------------------------------------------------
module random_permutation_shuffle #(
   parameter int MAX_LENGTH = rps_pkg::MAX_LENGTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rps_pkg::FRAC_W-1:0]  req_tdata,   // [15:0] random_fraction
   input  logic                        req_tuser,   // [0] action
   // response
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2*rps_pkg::DATA_W-1:0] rsp_tdata,  // [7:0] slot, [15:8] element
   output logic                        rsp_tlast,
   output logic                        rsp_tuser,   // [0] status
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rps_pkg::LEN_W-1:0]   csr_data     // perm_length
);

   import rps_pkg::*;

   localparam int IDX_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
   localparam int PROD_W = FRAC_W + CNT_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [LEN_W-1:0]    perm_length_ff;
   logic [CNT_W-1:0]    rem_ff, rem_in, rem_now, start_len;
   logic [IDX_W-1:0]    pick_ff, top_ff, pick_now, top_now;
   logic                exh_ff;
   logic                rsp_valid_ff;
   logic [2*DATA_W-1:0] rsp_data_ff;
   logic                rsp_last_ff, rsp_user_ff;

   logic                out_free, finish, accept, accept_draw, accept_start;
   logic [PROD_W-1:0]   prod;
   logic [31:0]         len_wide;
   logic [IDX_W-1:0]    pick_val, top_val;
   logic [IDX_W+DATA_W-1:0] slot_ext, elem_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_length_ff <= PERM_LENGTH_RST;
      end else if (csr_valid) begin
         perm_length_ff <= csr_data;
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign finish       = (state_ff == S_WRITE) && out_free;
   assign req_tready   = (state_ff == S_IDLE) || finish;
   assign accept       = req_tvalid && req_tready;
   assign accept_draw  = accept && (req_tuser == ACTION_DRAW);
   assign accept_start = accept && (req_tuser == ACTION_START);

   // count as it stands once the finishing draw has been retired
   assign rem_now  = (finish && !exh_ff) ? rem_ff - 1'b1 : rem_ff;
   assign prod     = PROD_W'(req_tdata) * PROD_W'(rem_now);
   assign pick_now = prod[FRAC_W +: IDX_W];
   assign top_now  = IDX_W'(rem_now - 1'b1);

   // length clamp to 1..MAX_LENGTH
   always_comb begin
      len_wide = 32'(perm_length_ff);
      if (len_wide == 32'd0) begin
         start_len = CNT_W'(1);
      end else if (len_wide > 32'(MAX_LENGTH)) begin
         start_len = CNT_W'(MAX_LENGTH);
      end else begin
         start_len = CNT_W'(len_wide);
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_now;
      if (accept_start) begin
         rem_in   = start_len;
         state_in = S_IDLE;
      end else if (accept_draw) begin
         state_in = S_READ;
      end else if (state_ff == S_READ) begin
         state_in = S_WRITE;
      end else if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rem_ff   <= CNT_W'(MAX_LENGTH);
         exh_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         if (accept_draw) begin
            exh_ff <= (rem_now == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_draw) begin
         pick_ff <= pick_now;
         top_ff  <= top_now;
      end
   end

   rps_table #(
      .MAX_LENGTH (MAX_LENGTH),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .clear_all (accept_start),
      .rd_en     (state_ff == S_READ),
      .rd_a_addr (pick_ff),
      .rd_b_addr (top_ff),
      .rd_a_data (pick_val),
      .rd_b_data (top_val),
      .wr_en     (finish && !exh_ff),
      .wr_addr   (pick_ff),
      .wr_data   (top_val)
   );

   // top slot is fixed now and never read again, so only the pick is written
   assign slot_ext = {{DATA_W{1'b0}}, top_ff};
   assign elem_ext = {{DATA_W{1'b0}}, pick_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         if (exh_ff) begin
            rsp_data_ff <= '0;
            rsp_last_ff <= 1'b0;
            rsp_user_ff <= STATUS_EXHAUSTED;
         end else begin
            rsp_data_ff <= {elem_ext[DATA_W-1:0], slot_ext[DATA_W-1:0]};
            rsp_last_ff <= (top_ff == '0);
            rsp_user_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hdl/rps_checker.sv =====
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks for the random permutation shuffle, bound to the top.
// ----------------------------------------------------------------------------
module rps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [2*rps_pkg::DATA_W-1:0] rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         rsp_tuser
);

   import rps_pkg::*;

   // held response transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // a draw occupies the table for its read cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACTION_DRAW) |=> !req_tready)
      else $error("request taken during table read");

   // exhausted status carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_EXHAUSTED) |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("exhausted response with non-zero fields");

   // last marks slot 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[DATA_W-1:0] == '0))
      else $error("last set on a slot other than 0");

endmodule

bind random_permutation_shuffle rps_checker u_rps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_random_permutation_shuffle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_permutation_shuffle
// Self-checking bench for the Fisher-Yates shuffle block. A short table of
// directed transactions (length extremes, exhausted draws, restarts) is
// followed by random phases, each with its own permutation length. Every
// result is compared against an in-bench shuffle predictor, with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_random_permutation_shuffle;
   import rps_pkg::*;

   localparam int          TABLE_DEPTH   = MAX_LENGTH_DEF;
   localparam int          ITEM_TARGET   = 1800;
   localparam int          SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] slot;
      logic [DATA_W-1:0] element;
      logic              last;
      logic              status;
   } draw_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_START, ROW_DRAW} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [15:0]  value;     // fraction for a draw, length for a csr write
      bit           typed;
      draw_type     result;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [FRAC_W-1:0]       req_tdata = '0;   // [15:0] random_fraction
   logic                    req_tuser = ACTION_START; // [0] action
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [2*DATA_W-1:0]     rsp_tdata;        // [7:0] slot, [15:8] element
   logic                    rsp_tlast;
   logic                    rsp_tuser;        // [0] status
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [LEN_W-1:0]        csr_data = '0;    // perm_length

   random_permutation_shuffle dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shuffle predictor state
   logic [DATA_W-1:0] order_mem [TABLE_DEPTH];
   bit                entry_valid [TABLE_DEPTH];
   int unsigned       remaining = TABLE_DEPTH;
   logic [LEN_W-1:0]  length_reg = PERM_LENGTH_RST;

   draw_type    expected_q [$];
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned perms_done = 0;
   int unsigned exhausted_seen = 0;
   int unsigned cycle_count = 0;
   bit          steady_run = 1'b0;   // no gaps or stalls in this phase
   int unsigned stall_left = 0;

   function automatic logic [DATA_W-1:0] table_value(input int unsigned idx);
      return entry_valid[idx] ? order_mem[idx] : idx[DATA_W-1:0];
   endfunction

   function automatic void shuffle_step(input logic action, input logic [FRAC_W-1:0] frac,
                                        output bit produced, output draw_type res);
      int unsigned       eff_len;
      int unsigned       top;
      int unsigned       pick;
      logic [DATA_W-1:0] picked_val;
      logic [DATA_W-1:0] top_val;
      res      = '0;
      produced = 1'b0;
      if (action == ACTION_START) begin
         eff_len = 32'(length_reg);
         if (eff_len < 1) eff_len = 1;
         if (eff_len > TABLE_DEPTH) eff_len = TABLE_DEPTH;
         foreach (entry_valid[i]) entry_valid[i] = 1'b0;
         remaining = eff_len;
      end else begin
         produced = 1'b1;
         if (remaining == 0) begin
            res.status = STATUS_EXHAUSTED;
         end else begin
            top        = remaining - 1;
            pick       = (32'(frac) * remaining) >> 16;
            picked_val = table_value(pick);
            top_val    = table_value(top);
            order_mem[pick]   = top_val;
            entry_valid[pick] = 1'b1;
            order_mem[top]    = picked_val;
            entry_valid[top]  = 1'b1;
            remaining   = top;
            res.slot    = top[DATA_W-1:0];
            res.element = picked_val;
            res.last    = (top == 0);
            res.status  = STATUS_OK;
         end
      end
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(input logic action, input logic [FRAC_W-1:0] frac,
                           input bit typed, input draw_type typed_res);
      bit          produced;
      draw_type    res;
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= frac;
      do @(posedge clock); while (!req_tready);
      shuffle_step(action, frac, produced, res);
      if (produced) expected_q.push_back(typed ? typed_res : res);
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for the block to go quiet: all results back, then a settling wait
   task automatic settle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      length_reg = value;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : result_check
      draw_type got;
      draw_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{slot: rsp_tdata[DATA_W-1:0], element: rsp_tdata[2*DATA_W-1:DATA_W],
                 last: rsp_tlast, status: rsp_tuser};
         results_seen++;
         if (got.status == STATUS_EXHAUSTED) exhausted_seen++;
         else if (got.last) perms_done++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result slot=%0d element=%0d last=%0b status=%0b",
                     $time, got.slot, got.element, got.last, got.status);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected slot=%0d element=%0d last=%0b status=%0b",
                        $time, want.slot, want.element, want.last, want.status);
               $display("%0t:          actual   slot=%0d element=%0d last=%0b status=%0b",
                        $time, got.slot, got.element, got.last, got.status);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
      $display("tb_random_permutation_shuffle: done, errors");
      $finish;
   end

   stim_row_type directed [25] = '{
      // straight after reset: a length of 256 is already in place
      '{ROW_DRAW,  16'h0000, 1'b1, '{8'd255, 8'd0,   1'b0, STATUS_OK}},
      '{ROW_DRAW,  16'hFFFF, 1'b1, '{8'd254, 8'd254, 1'b0, STATUS_OK}},
      '{ROW_DRAW,  16'h8000, 1'b0, '0},
      // zero length is taken as one
      '{ROW_CSR,   16'd0,    1'b0, '0},
      '{ROW_START, 16'h0000, 1'b0, '0},
      '{ROW_DRAW,  16'hFFFF, 1'b1, '{8'd0, 8'd0, 1'b1, STATUS_OK}},
      '{ROW_DRAW,  16'h1234, 1'b1, '{8'd0, 8'd0, 1'b0, STATUS_EXHAUSTED}},
      '{ROW_DRAW,  16'hFFFF, 1'b1, '{8'd0, 8'd0, 1'b0, STATUS_EXHAUSTED}},
      '{ROW_CSR,   16'd2,    1'b0, '0},
      '{ROW_START, 16'hFFFF, 1'b0, '0},
      '{ROW_DRAW,  16'hFFFF, 1'b1, '{8'd1, 8'd1, 1'b0, STATUS_OK}},
      '{ROW_DRAW,  16'h0000, 1'b1, '{8'd0, 8'd0, 1'b1, STATUS_OK}},
      '{ROW_DRAW,  16'h5555, 1'b1, '{8'd0, 8'd0, 1'b0, STATUS_EXHAUSTED}},
      '{ROW_START, 16'h0000, 1'b0, '0},
      '{ROW_START, 16'h0000, 1'b0, '0},
      '{ROW_DRAW,  16'h8000, 1'b0, '0},
      '{ROW_START, 16'h0000, 1'b0, '0},
      // over-range length is clipped to the table depth
      '{ROW_CSR,   16'd511,  1'b0, '0},
      '{ROW_START, 16'h0000, 1'b0, '0},
      '{ROW_DRAW,  16'hFFFF, 1'b1, '{8'd255, 8'd255, 1'b0, STATUS_OK}},
      '{ROW_DRAW,  16'hAAAA, 1'b0, '0},
      '{ROW_CSR,   16'd257,  1'b0, '0},
      '{ROW_START, 16'h0000, 1'b0, '0},
      '{ROW_DRAW,  16'h0001, 1'b0, '0},
      '{ROW_DRAW,  16'h7FFF, 1'b0, '0}
   };

   initial begin : stimulus
      int unsigned      r;
      int unsigned      eff_len;
      int unsigned      n_draws;
      int unsigned      restart_at;
      logic [LEN_W-1:0] len;
      logic [FRAC_W-1:0] frac;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         case (directed[i].kind)
            ROW_CSR:   write_length(directed[i].value[LEN_W-1:0]);
            ROW_START: send_req(ACTION_START, directed[i].value, 1'b0, '0);
            default:   send_req(ACTION_DRAW, directed[i].value, directed[i].typed,
                                directed[i].result);
         endcase
      end

      while (items_sent < ITEM_TARGET + 25) begin
         r = $urandom_range(0, 99);
         if (r < 60)      len = LEN_W'($urandom_range(1, 24));
         else if (r < 67) len = LEN_W'(0);
         else if (r < 72) len = LEN_W'(1);
         else if (r < 80) len = LEN_W'(256);
         else if (r < 88) len = LEN_W'($urandom_range(257, 511));
         else             len = LEN_W'($urandom_range(25, 255));
         write_length(len);
         steady_run = ($urandom_range(0, 4) == 0);
         eff_len = (len == 0) ? 1 : (32'(len) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(len);

         if ($urandom_range(0, 99) < 15) begin
            // noise: starts and draws in any order
            repeat ($urandom_range(4, 30))
               send_req($urandom_range(0, 1) ? ACTION_DRAW : ACTION_START,
                        16'($urandom_range(0, 65535)), 1'b0, '0);
         end else begin
            send_req(ACTION_START, 16'($urandom), 1'b0, '0);
            n_draws    = eff_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, eff_len) : n_draws + 1;
            for (int k = 0; k < n_draws; k++) begin
               if (k == restart_at) send_req(ACTION_START, 16'($urandom), 1'b0, '0);
               r = $urandom_range(0, 19);
               frac = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
               send_req(ACTION_DRAW, frac, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      steady_run = 1'b0;
      settle();
      if (expected_q.size() != 0) error_count++;
      $display("covered %0d request transactions and %0d checked results:", items_sent,
               results_seen);
      $display("  %0d permutations run to the end, %0d draws with nothing left", perms_done,
               exhausted_seen);
      if (error_count == 0) begin
         $display("tb_random_permutation_shuffle: done, clean");
      end else begin
         $display("tb_random_permutation_shuffle: done, errors");
      end
      $finish;
   end

endmodule
